FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define CHK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/lzss_pkg.sv
// ----------------------------------------------------------------------------
// lzss_pkg
// Types and constants of the LZSS window decoder.
// ----------------------------------------------------------------------------
package lzss_pkg;

   localparam int          WINDOW_SIZE = 4096;
   localparam int          RING_AW     = $clog2(WINDOW_SIZE);
   localparam int          DIST_W      = RING_AW + 1;
   localparam int          LEN_W       = 5;
   localparam logic [7:0]  FILL_BYTE   = 8'h20;
   localparam logic [11:0] POS_OFFSET  = 12'd18;
   localparam logic [4:0]  MIN_COPY    = 5'd3;

   typedef enum logic [1:0] {
      PHASE_FLAG  = 2'd0,
      PHASE_TOKEN = 2'd1,
      PHASE_PAIR  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_DECODE  = 3'd1,
      ST_EMIT    = 3'd2,
      ST_COPY_RD = 3'd3,
      ST_COPY_WR = 3'd4
   } state_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_MISMATCH = 2'd2
   } status_type;

   // one result word headed for the output register
   typedef struct packed {
      logic       valid;
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      status_type status;
   } emit_type;

   // history ring access
   typedef struct packed {
      logic               wr_en;
      logic [RING_AW-1:0] wr_addr;
      logic [7:0]         wr_data;
      logic               rd_en;
      logic [RING_AW-1:0] rd_addr;
   } ring_req_type;

endpackage

FILE: rtl/core/lzss_ring.sv
// ----------------------------------------------------------------------------
// lzss_ring
// History ring: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lzss_ring
   import lzss_pkg::*;
(
   input  logic         clock,
   input  ring_req_type ring_req,
   output logic [7:0]   rd_data
);

   logic [7:0] mem [WINDOW_SIZE];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ring_req.wr_en) begin
         mem[ring_req.wr_addr] <= ring_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_req.rd_en) begin
         rd_data_ff <= mem[ring_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/lzss_ctrl.sv
// ----------------------------------------------------------------------------
// lzss_ctrl
// Token parser and copy sequencer around one shared length adder.
// ----------------------------------------------------------------------------
module lzss_ctrl
   import lzss_pkg::*;
#(
   parameter int LENGTH_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_stream_end,
   output logic                   req_stall,
   input  logic [LENGTH_BITS-1:0] expected_length,
   input  logic                   slot_free,
   output emit_type               emit,
   output ring_req_type           ring_req,
   input  logic [7:0]             rd_data
);

   localparam int CW = LENGTH_BITS + 1;

   state_type                state_ff, state_in;
   phase_type                phase_ff, phase_in;
   logic [7:0]               flag_ff, flag_in;
   logic [2:0]               tok_ff, tok_in;
   logic [7:0]               low_ff, low_in;
   logic                     ovf_ff, ovf_in;
   logic [LENGTH_BITS-1:0]   count_ff, count_in;
   logic [7:0]               byte_ff, byte_in;
   logic                     end_ff, end_in;
   logic                     lit_ff, lit_in;
   logic [LEN_W-1:0]         left_ff, left_in;
   logic [DIST_W-1:0]        dist_ff, dist_in;
   logic [RING_AW-1:0]       src_ff, src_in;
   status_type               status_ff, status_in;

   logic                     active;
   logic                     is_lit;
   logic                     is_copy;
   logic [LEN_W-1:0]         copy_len;
   logic [RING_AW-1:0]       target;
   logic [RING_AW-1:0]       back;
   logic [CW-1:0]            addend;
   logic [CW-1:0]            sum;
   logic                     over;
   logic                     ovf_next;
   logic [7:0]               copy_byte;

   // shared length adder: count plus what this token will emit
   always_comb begin
      active   = !ovf_ff && (count_ff < expected_length);
      is_lit   = active && (phase_ff == PHASE_TOKEN) && flag_ff[tok_ff];
      is_copy  = active && (phase_ff == PHASE_PAIR);
      copy_len = MIN_COPY + {1'b0, byte_ff[3:0]};
      target   = {byte_ff[7:4], low_ff} + POS_OFFSET;
      back     = count_ff[RING_AW-1:0] - target - RING_AW'(1);
      if (is_lit) begin
         addend = CW'(1);
      end else if (is_copy) begin
         addend = CW'(copy_len);
      end else begin
         addend = '0;
      end
      sum       = {1'b0, count_ff} + addend;
      over      = is_copy && (sum > {1'b0, expected_length});
      ovf_next  = ovf_ff || over;
      copy_byte = (count_ff < LENGTH_BITS'(dist_ff)) ? FILL_BYTE : rd_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PHASE_FLAG;
         flag_ff  <= '0;
         tok_ff   <= '0;
         low_ff   <= '0;
         ovf_ff   <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         flag_ff  <= flag_in;
         tok_ff   <= tok_in;
         low_ff   <= low_in;
         ovf_ff   <= ovf_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      end_ff    <= end_in;
      lit_ff    <= lit_in;
      left_ff   <= left_in;
      dist_ff   <= dist_in;
      src_ff    <= src_in;
      status_ff <= status_in;
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      flag_in   = flag_ff;
      tok_in    = tok_ff;
      low_in    = low_ff;
      ovf_in    = ovf_ff;
      count_in  = count_ff;
      byte_in   = byte_ff;
      end_in    = end_ff;
      lit_in    = lit_ff;
      left_in   = left_ff;
      dist_in   = dist_ff;
      src_in    = src_ff;
      status_in = status_ff;
      req_stall = 1'b1;
      emit      = '0;
      ring_req  = '0;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               byte_in  = req_in_byte;
               end_in   = req_stream_end;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            ovf_in = ovf_next;
            if (ovf_next) begin
               status_in = STATUS_OVERFLOW;
            end else if (end_ff && (sum != {1'b0, expected_length})) begin
               status_in = STATUS_MISMATCH;
            end else begin
               status_in = STATUS_OK;
            end
            if (active) begin
               case (phase_ff)
                  PHASE_FLAG: begin
                     flag_in  = byte_ff;
                     tok_in   = '0;
                     phase_in = PHASE_TOKEN;
                  end
                  PHASE_TOKEN: begin
                     if (is_lit) begin
                        tok_in   = tok_ff + 3'd1;
                        phase_in = (tok_ff == 3'd7) ? PHASE_FLAG : PHASE_TOKEN;
                     end else begin
                        low_in   = byte_ff;
                        phase_in = PHASE_PAIR;
                     end
                  end
                  default: begin
                     tok_in   = tok_ff + 3'd1;
                     phase_in = (tok_ff == 3'd7) ? PHASE_FLAG : PHASE_TOKEN;
                  end
               endcase
            end
            lit_in  = is_lit;
            left_in = copy_len;
            dist_in = {1'b0, back} + DIST_W'(1);
            src_in  = target;
            if (is_lit) begin
               state_in = ST_EMIT;
            end else if (is_copy && !over) begin
               state_in = ST_COPY_RD;
            end else if (end_ff) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_EMIT: begin
            if (slot_free) begin
               emit.valid      = 1'b1;
               emit.out_byte   = lit_ff ? byte_ff : 8'd0;
               emit.byte_valid = lit_ff;
               emit.run_last   = 1'b1;
               emit.status     = status_ff;
               if (lit_ff) begin
                  ring_req.wr_en   = 1'b1;
                  ring_req.wr_addr = count_ff[RING_AW-1:0];
                  ring_req.wr_data = byte_ff;
                  count_in         = count_ff + LENGTH_BITS'(1);
               end
               if (end_ff) begin
                  phase_in = PHASE_FLAG;
                  flag_in  = '0;
                  tok_in   = '0;
                  low_in   = '0;
                  ovf_in   = 1'b0;
                  count_in = '0;
               end
               state_in = ST_IDLE;
            end
         end

         ST_COPY_RD: begin
            ring_req.rd_en   = 1'b1;
            ring_req.rd_addr = src_ff;
            state_in         = ST_COPY_WR;
         end

         ST_COPY_WR: begin
            if (slot_free) begin
               emit.valid       = 1'b1;
               emit.out_byte    = copy_byte;
               emit.byte_valid  = 1'b1;
               emit.run_last    = (left_ff == LEN_W'(1));
               emit.status      = status_ff;
               ring_req.wr_en   = 1'b1;
               ring_req.wr_addr = count_ff[RING_AW-1:0];
               ring_req.wr_data = copy_byte;
               count_in         = count_ff + LENGTH_BITS'(1);
               src_in           = src_ff + RING_AW'(1);
               left_in          = left_ff - LEN_W'(1);
               if (left_ff == LEN_W'(1)) begin
                  if (end_ff) begin
                     phase_in = PHASE_FLAG;
                     flag_in  = '0;
                     tok_in   = '0;
                     low_in   = '0;
                     ovf_in   = 1'b0;
                     count_in = '0;
                  end
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_COPY_RD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/lzss_window_decoder.sv
// ----------------------------------------------------------------------------
// lzss_window_decoder
// A literal passes the DECODE and EMIT states and then the output register before it
//   shows at rsp; a copy reads and writes the ring once per byte (COPY_RD, COPY_WR).
//   Words are taken only in IDLE, after the last one is done; a stalled rsp holds EMIT
//   and COPY_WR. The ring's one read port with registered data sets the copy step.
// Reset: synchronous, active high; clears parse state, counters, expected_length.
// ----------------------------------------------------------------------------
module lzss_window_decoder
   import lzss_pkg::*;
#(
   parameter int LENGTH_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,

   // compressed input words
   input  logic        req_valid,
   input  logic [7:0]  req_in_byte,
   input  logic        req_stream_end,
   output logic        req_stall,

   // decoded result words
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_run_last,
   output logic [1:0]  rsp_status,
   input  logic        rsp_stall,

   // expected_length register write
   input  logic        csr_valid,
   input  logic [23:0] csr_expected_length,
   output logic        csr_ready
);

   logic [LENGTH_BITS-1:0] expected_ff, expected_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_byte_ff;
   logic                   rsp_bv_ff;
   logic                   rsp_last_ff;
   status_type             rsp_status_ff;
   logic                   slot_free;
   emit_type               emit;
   ring_req_type           ring_req;
   logic [7:0]             rd_data;

   // Register writes are only expected between streams, so the port is
   // always open. Value is kept to LENGTH_BITS bits.
   assign csr_ready = 1'b1;

   always_comb begin
      expected_in = expected_ff;
      if (csr_valid) begin
         expected_in = LENGTH_BITS'(csr_expected_length);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
      end else begin
         expected_ff <= expected_in;
      end
   end

   // Output register. The sequencer may load a word whenever the register
   // is empty or is being drained this cycle, so a stalled consumer only
   // holds the sequencer, never corrupts a word.
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit.valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload loads only with a new word
   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_byte_ff   <= emit.out_byte;
         rsp_bv_ff     <= emit.byte_valid;
         rsp_last_ff   <= emit.run_last;
         rsp_status_ff <= emit.status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_byte_valid = rsp_bv_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;

   // Parser and copy sequencer. A copy walks the ring one byte per
   // read/write pair; positions before output zero read as a space.
   lzss_ctrl #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_in_byte     (req_in_byte),
      .req_stream_end  (req_stream_end),
      .req_stall       (req_stall),
      .expected_length (expected_ff),
      .slot_free       (slot_free),
      .emit            (emit),
      .ring_req        (ring_req),
      .rd_data         (rd_data)
   );

   // 4K history, no reset: a byte read from a position not yet written is replaced by the fill byte
   lzss_ring u_ring (
      .clock    (clock),
      .ring_req (ring_req),
      .rd_data  (rd_data)
   );

endmodule

FILE: rtl/core/lzss_check.sv
// ----------------------------------------------------------------------------
// lzss_check
// Port-level checks on the LZSS window decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lzss_check
   import lzss_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_run_last,
   input logic [1:0] rsp_status,
   input logic       rsp_stall
);

   // a stalled result word holds
   `CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_byte))

   // an empty word only closes a stream
   `CHK_IMPLY(a_empty_last, rsp_valid && !rsp_byte_valid, rsp_run_last && rsp_out_byte == 8'd0)

   // overflow shows only on the empty closing word
   `CHK_IMPLY(a_ovf_empty, rsp_valid && rsp_status == STATUS_OVERFLOW, !rsp_byte_valid && rsp_run_last)

   // one word at a time: busy right after an accept
   `CHK_NEXT(a_busy, req_valid && !req_stall, req_stall)

endmodule

bind lzss_window_decoder lzss_check u_check (.*);

FILE: tb/lzss_decode_sb_pkg.sv
// ----------------------------------------------------------------------------
// lzss_decode_sb_pkg
// Scoreboard for the LZSS window decoder: decodes each accepted compressed
// word on its own copy of the parse state and history, queues the decoded
// words it predicts and compares them with what leaves the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package lzss_decode_sb_pkg;
   import lzss_pkg::*;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      status_type status;
   } decoded_word_type;

   class lzss_scoreboard;
      logic [7:0]       history [WINDOW_SIZE];
      logic [23:0]      length_cfg;
      logic [23:0]      produced;
      logic [7:0]       flags;
      logic [2:0]       token_no;
      phase_type        phase;
      logic [7:0]       low_byte;
      bit               overflowed;
      logic [7:0]       run_bytes [$];
      decoded_word_type predicted_out [$];
      int               failures;

      function new();
         length_cfg = '0;
         failures   = 0;
         restart();
      endfunction

      function void restart();
         produced   = '0;
         flags      = '0;
         token_no   = '0;
         phase      = PHASE_FLAG;
         low_byte   = '0;
         overflowed = 1'b0;
      endfunction

      function void set_length(logic [23:0] value);
         length_cfg = value;
      endfunction

      function int outstanding();
         return predicted_out.size();
      endfunction

      function void put_byte(logic [7:0] value);
         history[produced[11:0]] = value;
         produced = produced + 24'd1;
         run_bytes.push_back(value);
      endfunction

      function void next_token();
         token_no = token_no + 3'd1;
         phase    = (token_no == 3'd0) ? PHASE_FLAG : PHASE_TOKEN;
      endfunction

      // Decode one accepted compressed word and queue the words it yields.
      function void decode_word(logic [7:0] in_byte, logic stream_end);
         logic [11:0]      target;
         logic [12:0]      src_dist;
         logic [4:0]       len;
         status_type       st;
         decoded_word_type w;
         run_bytes.delete();
         if (!overflowed && produced < length_cfg) begin
            case (phase)
               PHASE_FLAG: begin
                  flags    = in_byte;
                  token_no = '0;
                  phase    = PHASE_TOKEN;
               end
               PHASE_TOKEN: begin
                  if (flags[token_no]) begin
                     put_byte(in_byte);
                     next_token();
                  end else begin
                     low_byte = in_byte;
                     phase    = PHASE_PAIR;
                  end
               end
               PHASE_PAIR: begin
                  // source is the latest position with these low 12 bits, 1..4096 back
                  target   = {in_byte[7:4], low_byte} + POS_OFFSET;
                  len      = MIN_COPY + {1'b0, in_byte[3:0]};
                  src_dist = {1'b0, produced[11:0] - target - 12'd1} + 13'd1;
                  if ({1'b0, produced} + 25'(len) > {1'b0, length_cfg})
                     overflowed = 1'b1;
                  else
                     for (int j = 0; j < len; j++)
                        put_byte((produced < 24'(src_dist)) ? FILL_BYTE
                                 : history[produced[11:0] - src_dist[11:0]]);
                  next_token();
               end
               default: ;
            endcase
         end

         if (overflowed)
            st = STATUS_OVERFLOW;
         else if (stream_end && produced != length_cfg)
            st = STATUS_MISMATCH;
         else
            st = STATUS_OK;

         foreach (run_bytes[k]) begin
            w.out_byte   = run_bytes[k];
            w.byte_valid = 1'b1;
            w.run_last   = (k == run_bytes.size() - 1);
            w.status     = st;
            predicted_out.push_back(w);
         end
         if (stream_end) begin
            if (run_bytes.size() == 0) begin
               w.out_byte   = 8'h00;
               w.byte_valid = 1'b0;
               w.run_last   = 1'b1;
               w.status     = st;
               predicted_out.push_back(w);
            end
            restart();
         end
      endfunction

      function void complain(string msg);
         failures++;
         if (failures <= 10)
            $display("%0t: %s", $time, msg);
      endfunction

      function void compare_output(logic [7:0] out_byte, logic byte_valid,
                                   logic run_last, logic [1:0] status);
         decoded_word_type want;
         if (predicted_out.size() == 0) begin
            complain($sformatf("unexpected word: byte %02h valid %0b last %0b status %0d",
                               out_byte, byte_valid, run_last, status));
            return;
         end
         want = predicted_out.pop_front();
         if (out_byte !== want.out_byte || byte_valid !== want.byte_valid ||
             run_last !== want.run_last || status !== want.status)
            complain($sformatf({"mismatch: expected byte %02h valid %0b last %0b status %0d,",
                                " got byte %02h valid %0b last %0b status %0d"},
                               want.out_byte, want.byte_valid, want.run_last, want.status,
                               out_byte, byte_valid, run_last, status));
      endfunction

      function void close_out();
         if (predicted_out.size() != 0)
            complain($sformatf("%0d decoded words never arrived", predicted_out.size()));
      endfunction
   endclass

endpackage

FILE: tb/tb_lzss_window_decoder.sv
// ----------------------------------------------------------------------------
// tb_lzss_window_decoder
// Feeds compressed streams to the LZSS window decoder and checks every
// decoded word against a scoreboard that decodes the same words. A short
// directed part hits literals, copies from before the start of output,
// overlapping copies, length reached, copy overflow and a cut-off pair; then
// random streams run under several length settings with random idling on
// both sides, one long result stall and pauses until the block drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lzss_window_decoder;
   import lzss_pkg::*;
   import lzss_decode_sb_pkg::*;

   localparam int          RANDOM_WORDS  = 310;
   localparam int          SETTLE_CYCLES = 64;   // longest copy plus pipeline, with margin
   localparam int          STARVE_CYCLES = 400;
   localparam logic [23:0] LEN_MAX       = 24'hFF_FFFF;

   // shapes of generated streams
   typedef enum logic [1:0] {
      STREAM_EXACT,   // lands exactly on the length, tail ignored
      STREAM_SHORT,   // stops early: length mismatch, maybe a cut-off pair
      STREAM_OVER,    // ends with a copy that passes the length
      STREAM_NOISE    // random bytes
   } stream_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid      = 1'b0;
   logic [7:0]  req_in_byte    = '0;
   logic        req_stream_end = 1'b0;
   logic        req_stall;

   logic        rsp_valid;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_run_last;
   logic [1:0]  rsp_status;
   logic        rsp_stall = 1'b1;

   logic        csr_valid           = 1'b0;
   logic [23:0] csr_expected_length = '0;
   logic        csr_ready;

   lzss_scoreboard sb;
   int             words_sent = 0;   // accepted words while a nonzero length is set
   bit             req_eager  = 1'b0; // sender offers back to back
   bit             rsp_eager  = 1'b0; // receiver takes back to back
   bit             hold_rsp   = 1'b0; // asks the receiver for its one long stall

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lzss_window_decoder #(
      .LENGTH_BITS(24)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_in_byte         (req_in_byte),
      .req_stream_end      (req_stream_end),
      .req_stall           (req_stall),
      .rsp_valid           (rsp_valid),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_byte_valid      (rsp_byte_valid),
      .rsp_run_last        (rsp_run_last),
      .rsp_status          (rsp_status),
      .rsp_stall           (rsp_stall),
      .csr_valid           (csr_valid),
      .csr_expected_length (csr_expected_length),
      .csr_ready           (csr_ready)
   );

   // Offer one compressed word after a random gap and hold it until taken.
   // Valid stays high into the next call; only a gap or a drain lowers it.
   task automatic send_word(input logic [7:0] value, input logic last);
      int gap;
      gap = req_eager ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_in_byte    <= value;
      req_stream_end <= last;
      do @(posedge clock); while (req_stall);
      sb.decode_word(value, last);
      if (sb.length_cfg != '0)
         words_sent++;
   endtask

   // Stop offering until every predicted word is out, then let a word that
   // yields nothing finish inside the block.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [23:0] value);
      csr_valid           <= 1'b1;
      csr_expected_length <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_length(value);
   endtask

   // Build one stream as groups of a flag byte plus up to eight tokens, then send
   // it with stream_end on its last byte. Copies mostly point at recent
   // output (often overlapping), sometimes anywhere in the ring.
   task automatic send_stream(input stream_kind_type kind);
      logic [7:0]  stream_q [$];
      logic [7:0]  group [$];
      logic [7:0]  flag;
      logic [11:0] pos;
      int unsigned limit, want, made, room, len, reach, slack, tail;
      bit          blown, finished;
      limit = sb.length_cfg;
      made  = 0;
      slack = 0;
      blown = 1'b0;
      case (kind)
         STREAM_EXACT: want = limit;
         STREAM_SHORT: want = $urandom_range(0, (limit > 60) ? 60 : limit - 1);
         STREAM_OVER: begin
            slack = $urandom_range(1, (limit > 15) ? 15 : limit);
            want  = limit - slack;
         end
         default: want = 0;
      endcase

      if (kind == STREAM_NOISE) begin
         repeat ($urandom_range(1, 12)) stream_q.push_back(8'($urandom));
      end else begin
         finished = (want == 0 && kind != STREAM_OVER);
         while (!finished) begin
            flag = 8'($urandom);
            group.delete();
            for (int k = 0; k < 8; k++) begin
               room = want - made;
               if (room == 0 && (kind != STREAM_OVER || blown))
                  break;
               // at the length in an overflow stream: one copy that runs past it
               if (room == 0)
                  blown = 1'b1;
               if (blown || (room >= 3 && $urandom_range(0, 2) != 0)) begin
                  len = blown ? $urandom_range(slack + 1, 18)
                              : $urandom_range(3, (room > 18) ? 18 : room);
                  if (made == 0 || $urandom_range(0, 3) == 0) begin
                     pos = 12'($urandom);
                  end else begin
                     reach = $urandom_range(1, (made > WINDOW_SIZE) ? WINDOW_SIZE : made);
                     pos   = 12'(made - reach) - POS_OFFSET;
                  end
                  flag[k] = 1'b0;
                  group.push_back(pos[7:0]);
                  group.push_back({pos[11:8], 4'(len - 3)});
                  if (blown)
                     break;
                  made += len;
               end else begin
                  flag[k] = 1'b1;
                  group.push_back(8'($urandom));
                  made++;
               end
            end
            stream_q.push_back(flag);
            foreach (group[i]) stream_q.push_back(group[i]);
            finished = (made == want) && (kind != STREAM_OVER || blown);
         end
         // trailing bytes: ignored once the length is hit or after overflow,
         // otherwise a literal, a new flag or a pair cut off by the end
         tail = (kind == STREAM_OVER) ? $urandom_range(0, 3) : $urandom_range(0, 1);
         repeat (tail) stream_q.push_back(8'($urandom));
      end
      if (stream_q.size() == 0)
         stream_q.push_back(8'($urandom));
      foreach (stream_q[i]) send_word(stream_q[i], i == stream_q.size() - 1);
   endtask

   // Receiver: random stall before each word, stretches of none, and one
   // long hold-off on request so the block backs up into its input.
   initial begin : result_sink
      int gap;
      int starve;
      bit held;
      gap    = 0;
      starve = 0;
      held   = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.compare_output(rsp_out_byte, rsp_byte_valid, rsp_run_last, rsp_status);
            if ($urandom_range(0, 39) == 0)
               rsp_eager = !rsp_eager;
            gap = rsp_eager ? 0 : $urandom_range(0, 4);
         end
         if (hold_rsp && !held) begin
            starve = STARVE_CYCLES;
            held   = 1'b1;
         end
         if (starve > 0) begin
            starve--;
            rsp_stall <= 1'b1;
         end else if (gap > 0) begin
            gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      logic [23:0]     len_cfg;
      int              n_streams;
      int              pick;
      stream_kind_type kind;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Length is zero out of reset: words are ignored, the end still reports ok.
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b1);
      drain();

      write_length(24'd27);
      // flag 0x05: literal, copy, literal, then copies
      send_word(8'h05, 1'b0);
      send_word(8'h00, 1'b0);   // literal 0x00
      send_word(8'h00, 1'b0);   // copy of 3 from before output start: fill bytes
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);   // literal 0xFF
      send_word(8'hF2, 1'b0);   // copy of 4 at distance 1: repeats the last byte
      send_word(8'hF1, 1'b0);
      send_word(8'hF2, 1'b0);   // copy of 18 at distance 5 lands exactly on 27
      send_word(8'hFF, 1'b0);
      send_word(8'hAA, 1'b0);   // length reached: ignored
      send_word(8'h55, 1'b1);   // ignored, end reports ok with no byte

      // all copies; the second runs past the length
      send_word(8'h00, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h0F, 1'b0);
      send_word(8'h12, 1'b0);
      send_word(8'hEF, 1'b0);
      send_word(8'h00, 1'b1);   // end reports overflow

      // a copy pair cut off by the end: dropped, length mismatch
      send_word(8'hFE, 1'b0);
      send_word(8'h80, 1'b1);

      // Random part: each setting runs a few streams. Setting 0 is the largest
      // length, 2 is zero, 4 is tiny; the long result stall starts with 1.
      words_sent = 0;
      for (int ph = 0; words_sent < RANDOM_WORDS || ph < 5; ph++) begin
         case (ph)
            0:       len_cfg = LEN_MAX;
            2:       len_cfg = '0;
            4:       len_cfg = 24'($urandom_range(1, 3));
            default: len_cfg = 24'($urandom_range(4, 90));
         endcase
         drain();
         write_length(len_cfg);
         if (ph == 1)
            hold_rsp <= 1'b1;
         n_streams = (len_cfg == '0) ? 1 : $urandom_range(2, 4);
         for (int s = 0; s < n_streams; s++) begin
            if (s > 0 && (ph == 3 || $urandom_range(0, 5) == 0))
               drain();
            req_eager = ($urandom_range(0, 3) == 0);
            if (len_cfg == '0) begin
               kind = STREAM_NOISE;
            end else if (len_cfg == LEN_MAX) begin
               kind = ($urandom_range(0, 3) == 0) ? STREAM_NOISE : STREAM_SHORT;
            end else begin
               pick = $urandom_range(0, 19);
               kind = (pick < 8)  ? STREAM_EXACT :
                      (pick < 13) ? STREAM_SHORT :
                      (pick < 17) ? STREAM_OVER  : STREAM_NOISE;
            end
            send_stream(kind);
         end
      end

      drain();
      sb.close_out();
      if (sb.failures == 0)
         $display("** lzss_window_decoder: PASSED **");
      else
         $display("** lzss_window_decoder: FAILED **");
      $finish;
   end

   // hang guard, many times the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("** lzss_window_decoder: FAILED **");
      $finish;
   end

endmodule
